/* rtl/apfc_pkg.sv */
// Package for the anchored playback frame clock: widths, command and status codes,
// configuration register indexes and the request and result types of the multiply-divide engine.
// Depends on nothing; every other file of the block imports it.
package apfc_pkg;

    // Field widths
    localparam int W_VAL  = 64;
    localparam int W_OP   = 3;
    localparam int W_FPS  = 20;
    localparam int W_SNUM = 17;
    localparam int W_SDEN = 16;
    localparam int W_ST   = 2;
    localparam int W_CIDX = 2;

    // Engine widths: the largest scale factor is 1e9 * fps_den * rate_den (66 bits)
    localparam int W_NSC  = 30;
    localparam int W_FA   = W_FPS + W_SNUM;
    localparam int W_FT   = W_FPS + W_SDEN;
    localparam int W_OPR  = W_FT + W_NSC;
    localparam int W_ALU  = W_OPR + 1;

    localparam logic [W_NSC-1:0] NS_PER_SEC = W_NSC'(1000000000);

    // Commands
    localparam logic [W_OP-1:0] OP_PLAY  = 3'd0;
    localparam logic [W_OP-1:0] OP_PAUSE = 3'd1;
    localparam logic [W_OP-1:0] OP_SEEK  = 3'd2;
    localparam logic [W_OP-1:0] OP_FRAME = 3'd3;
    localparam logic [W_OP-1:0] OP_TIME  = 3'd4;

    // Status codes
    localparam logic [W_ST-1:0] ST_OK        = 2'd0;
    localparam logic [W_ST-1:0] ST_ZERO_RATE = 2'd1;
    localparam logic [W_ST-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [W_ST-1:0] ST_PAUSED    = 2'd3;

    // Configuration register indexes
    localparam logic [W_CIDX-1:0] CFG_FPS_NUM = 2'd0;
    localparam logic [W_CIDX-1:0] CFG_FPS_DEN = 2'd1;

    // Reset values of the frame rate registers
    localparam logic [W_FPS-1:0] FPS_NUM_RESET = 20'd30;
    localparam logic [W_FPS-1:0] FPS_DEN_RESET = 20'd1;

    // Request to the multiply-divide engine: floor(mag * mul / div) and its remainder
    typedef struct packed {
        logic             start;
        logic [W_VAL-1:0] mag;
        logic [W_OPR-1:0] mul;
        logic [W_OPR-1:0] div;
    } t_md_req;

    // Result of the multiply-divide engine
    typedef struct packed {
        logic             done;
        logic             ovf;
        logic             rem_nz;
        logic [W_VAL-1:0] quot;
    } t_md_res;

endpackage

/* rtl/apfc_addsub.sv */
// Shared adder and subtractor of the multiply-divide engine.
// Depends on apfc_pkg for its width.
module apfc_addsub
    import apfc_pkg::*;
(
    input  logic [W_ALU-1:0] i_a,
    input  logic [W_ALU-1:0] i_b,
    input  logic             i_sub,
    output logic [W_ALU-1:0] o_sum,
    output logic             o_carry
);

    logic [W_ALU-1:0] b_eff;
    logic [W_ALU:0]   full;

    // Subtraction is a plus the inverse of b plus one; carry out means no borrow.
    assign b_eff   = i_sub ? ~i_b : i_b;
    assign full    = {1'b0, i_a} + {1'b0, b_eff} + {{W_ALU{1'b0}}, i_sub};
    assign o_sum   = full[W_ALU-1:0];
    assign o_carry = full[W_ALU];

endmodule

/* rtl/apfc_muldiv.sv */
// Iterative multiply-divide engine: shift-add product then restoring division,
// both through one shared adder. Depends on apfc_pkg and apfc_addsub.
module apfc_muldiv
    import apfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_res o_res
);

    localparam int CNT_W = $clog2(W_VAL);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W_VAL - 1);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_MUL  = 3'd1;
    localparam logic [2:0] E_CHK  = 3'd2;
    localparam logic [2:0] E_DIV  = 3'd3;
    localparam logic [2:0] E_DONE = 3'd4;

    logic [2:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W_OPR-1:0] r_hi, n_hi;
    logic [W_VAL-1:0] r_lo, n_lo;
    logic [W_OPR-1:0] r_mul, n_mul;
    logic [W_OPR-1:0] r_div, n_div;
    logic             r_ovf, n_ovf;

    logic [W_ALU-1:0] alu_a, alu_b, alu_sum;
    logic             alu_sub, alu_carry;

    apfc_addsub u_addsub (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    // Operand selection for the shared adder in each phase.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_phase)
            E_MUL: begin
                alu_a = {1'b0, r_hi};
                alu_b = r_lo[0] ? {1'b0, r_mul} : '0;
            end
            E_CHK: begin
                alu_a   = {1'b0, r_hi};
                alu_b   = {1'b0, r_div};
                alu_sub = 1'b1;
            end
            E_DIV: begin
                alu_a   = {r_hi, r_lo[W_VAL-1]};
                alu_b   = {1'b0, r_div};
                alu_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer: 64 product steps, one range check, 64 quotient steps.
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_mul   = r_mul;
        n_div   = r_div;
        n_ovf   = r_ovf;
        unique case (r_phase)
            E_IDLE: begin
                if (i_req.start) begin
                    n_hi    = '0;
                    n_lo    = i_req.mag;
                    n_mul   = i_req.mul;
                    n_div   = i_req.div;
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_phase = E_MUL;
                end
            end
            E_MUL: begin
                n_hi  = alu_sum[W_ALU-1:1];
                n_lo  = {alu_sum[0], r_lo[W_VAL-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_phase = E_CHK;
                end
            end
            E_CHK: begin
                // A quotient of 2^64 or more cannot be represented.
                n_cnt = '0;
                if (alu_carry) begin
                    n_ovf   = 1'b1;
                    n_phase = E_DONE;
                end else begin
                    n_phase = E_DIV;
                end
            end
            E_DIV: begin
                if (alu_carry) begin
                    n_hi = alu_sum[W_OPR-1:0];
                end else begin
                    n_hi = {r_hi[W_OPR-2:0], r_lo[W_VAL-1]};
                end
                n_lo  = {r_lo[W_VAL-2:0], alu_carry};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_phase = E_DONE;
                end
            end
            E_DONE: begin
                n_phase = E_IDLE;
            end
            default: begin
                n_phase = E_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= E_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_mul <= n_mul;
        r_div <= n_div;
    end

    assign o_res.done   = (r_phase == E_DONE);
    assign o_res.ovf    = r_ovf;
    assign o_res.rem_nz = |r_hi;
    assign o_res.quot   = r_lo;

endmodule

/* rtl/anchored_playback_frame_clock_core.sv */
// Anchored playback frame clock, top level: command sequencer, clock state and output register.
// Depends on apfc_pkg and apfc_muldiv (which uses apfc_addsub).
//
// The block keeps an anchor frame, an anchor time in nanoseconds, a signed rational play rate
// and a running flag, and answers one transaction with exactly one result. Commands that need
// the running mapping (play or pause while running, frame query and frame-time query while
// running) go through the multiply-divide engine, which forms a shift-add product and then a
// restoring division through a single 67-bit adder. Every other command goes from the decide
// state straight to the done state. One command is worked on at a time: the input is ready
// only while the sequencer is idle, and a finished result waits in the output register while
// the next transaction is taken. The user must write the frame rate registers through the
// configuration port only while the block is idle; the block itself does not enforce this.
// Indexes beyond the two registers are ignored.
module anchored_playback_frame_clock_core
    import apfc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [W_CIDX-1:0]       i_cfg_idx,
    input  logic [W_FPS-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [W_OP-1:0]         i_operation,
    input  logic signed [W_VAL-1:0] i_now_ns,
    input  logic signed [W_VAL-1:0] i_frame_number,
    input  logic signed [W_SNUM-1:0] i_speed_numerator,
    input  logic [W_SDEN-1:0]       i_speed_denominator,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [W_VAL-1:0] o_frame_out,
    output logic signed [W_VAL-1:0] o_time_out,
    output logic [W_ST-1:0]         o_status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_PROD   = 3'd2;
    localparam logic [2:0] S_START  = 3'd3;
    localparam logic [2:0] S_RUN    = 3'd4;
    localparam logic [2:0] S_SIGN   = 3'd5;
    localparam logic [2:0] S_SUM    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [W_VAL:0] MAG_NEG_MAX = (W_VAL+1)'(1) << (W_VAL - 1);

    // Control state
    logic [2:0]              r_state, n_state;
    logic                    r_o_valid, n_o_valid;
    logic                    r_commit, n_commit;
    logic [W_FPS-1:0]        r_fps_num, r_fps_den;
    logic signed [W_VAL-1:0] r_anchor_frame, n_anchor_frame;
    logic signed [W_VAL-1:0] r_anchor_time, n_anchor_time;
    logic signed [W_SNUM-1:0] r_rate_num, n_rate_num;
    logic [W_SDEN-1:0]       r_rate_den, n_rate_den;
    logic                    r_running, n_running;

    // Transaction payload and working values
    logic [W_OP-1:0]         r_op;
    logic signed [W_VAL-1:0] r_now, r_frame;
    logic signed [W_SNUM-1:0] r_snum;
    logic [W_SDEN-1:0]       r_sden;
    logic signed [W_VAL-1:0] r_x, n_x;
    logic [W_FA-1:0]         r_a, n_a;
    logic [W_FT-1:0]         r_t, n_t;
    logic [W_OPR-1:0]        r_b, n_b;
    logic                    r_neg, n_neg;
    logic                    r_up, n_up;
    logic [W_VAL:0]          r_m, n_m;
    logic signed [W_VAL-1:0] r_off, n_off;
    logic signed [W_VAL-1:0] r_cur, n_cur;
    logic signed [W_VAL-1:0] r_fo, n_fo;
    logic signed [W_VAL-1:0] r_to, n_to;
    logic [W_ST-1:0]         r_st, n_st;
    logic signed [W_VAL-1:0] r_o_frame, n_o_frame;
    logic signed [W_VAL-1:0] r_o_time, n_o_time;
    logic [W_ST-1:0]         r_o_status, n_o_status;

    // Helpers
    logic                    accept;
    logic                    is_time;
    logic                    zero_rate;
    logic [W_SNUM-1:0]       rmag;
    logic signed [W_VAL-1:0] diff_a, diff_b, diff;
    logic                    diff_ovf;
    logic signed [W_VAL-1:0] sum_base, sum;
    logic                    sum_ovf;
    logic [W_VAL:0]          neg_m;
    logic                    xneg, neg;
    t_md_req                 md_req;
    t_md_res                 md_res;

    assign accept    = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign is_time   = (r_op == OP_TIME);
    assign zero_rate = (r_fps_num == '0) || (r_fps_den == '0) ||
                       (r_rate_num == '0) || (r_rate_den == '0);
    assign rmag      = r_rate_num[W_SNUM-1] ? W_SNUM'(-r_rate_num) : W_SNUM'(r_rate_num);

    // Offset from the anchor: elapsed time for a frame query, play or pause; frame distance for a time query.
    assign diff_a   = is_time ? r_frame : r_now;
    assign diff_b   = is_time ? r_anchor_frame : r_anchor_time;
    assign diff     = diff_a - diff_b;
    assign diff_ovf = (diff_a[W_VAL-1] != diff_b[W_VAL-1]) &&
                      (diff[W_VAL-1] != diff_a[W_VAL-1]);
    assign xneg     = diff[W_VAL-1];
    assign neg      = xneg ^ r_rate_num[W_SNUM-1];

    // Final addition back onto the anchor.
    assign sum_base = is_time ? r_anchor_time : r_anchor_frame;
    assign sum      = sum_base + r_off;
    assign sum_ovf  = (sum_base[W_VAL-1] == r_off[W_VAL-1]) &&
                      (sum[W_VAL-1] != sum_base[W_VAL-1]);
    assign neg_m    = -r_m;

    // Engine request: magnitude times one scale factor over the other.
    assign md_req.start = (r_state == S_START);
    assign md_req.mag   = r_x[W_VAL-1] ? W_VAL'(-r_x) : W_VAL'(r_x);
    assign md_req.mul   = is_time ? r_b : W_OPR'(r_a);
    assign md_req.div   = is_time ? W_OPR'(r_a) : r_b;

    apfc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_res   (md_res)
    );

    // Command sequencer.
    always_comb begin
        n_state        = r_state;
        n_commit       = r_commit;
        n_anchor_frame = r_anchor_frame;
        n_anchor_time  = r_anchor_time;
        n_rate_num     = r_rate_num;
        n_rate_den     = r_rate_den;
        n_running      = r_running;
        n_x            = r_x;
        n_a            = r_a;
        n_t            = r_t;
        n_b            = r_b;
        n_neg          = r_neg;
        n_up           = r_up;
        n_m            = r_m;
        n_off          = r_off;
        n_cur          = r_cur;
        n_fo           = r_fo;
        n_to           = r_to;
        n_st           = r_st;
        n_o_valid      = r_o_valid && !i_ready;
        n_o_frame      = r_o_frame;
        n_o_time       = r_o_time;
        n_o_status     = r_o_status;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_fo     = '0;
                n_to     = '0;
                n_st     = ST_OK;
                n_commit = 1'b0;
                n_cur    = r_anchor_frame;
                n_state  = S_DONE;
                case (r_op)
                    OP_PLAY: begin
                        if (r_snum == '0 || r_sden == '0) begin
                            n_st = ST_ZERO_RATE;
                        end else if (!r_running) begin
                            n_commit = 1'b1;
                        end else begin
                            n_state = S_PROD;
                        end
                    end
                    OP_PAUSE: begin
                        if (r_running) begin
                            n_state = S_PROD;
                        end
                    end
                    OP_SEEK: begin
                        n_commit = 1'b1;
                    end
                    OP_FRAME: begin
                        if (!r_running) begin
                            n_fo = r_anchor_frame;
                        end else begin
                            n_state = S_PROD;
                        end
                    end
                    OP_TIME: begin
                        if (r_running) begin
                            n_state = S_PROD;
                        end else if (r_frame == r_anchor_frame) begin
                            n_to = r_anchor_time;
                        end else begin
                            n_st = ST_PAUSED;
                        end
                    end
                    default: begin
                    end
                endcase
                // The running mapping needs nonzero rates and a representable offset.
                if (n_state == S_PROD) begin
                    if (zero_rate) begin
                        n_st    = ST_ZERO_RATE;
                        n_state = S_DONE;
                    end else if (diff_ovf) begin
                        n_st    = ST_OVERFLOW;
                        n_state = S_DONE;
                    end
                end
                n_x   = diff;
                n_neg = neg;
                // Floor for frames; for times, round up going forward and down in reverse.
                n_up  = is_time ? (r_rate_num[W_SNUM-1] ? neg : !neg) : neg;
                n_a   = W_FA'(r_fps_num) * W_FA'(rmag);
                n_t   = W_FT'(r_fps_den) * W_FT'(r_rate_den);
            end
            S_PROD: begin
                n_b     = W_OPR'(r_t) * W_OPR'(NS_PER_SEC);
                n_state = S_START;
            end
            S_START: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (md_res.done) begin
                    if (md_res.ovf) begin
                        n_st    = ST_OVERFLOW;
                        n_state = S_DONE;
                    end else begin
                        n_m     = {1'b0, md_res.quot} +
                                  {{W_VAL{1'b0}}, (r_up && md_res.rem_nz)};
                        n_state = S_SIGN;
                    end
                end
            end
            S_SIGN: begin
                n_state = S_SUM;
                if (r_neg) begin
                    if (r_m > MAG_NEG_MAX) begin
                        n_st    = ST_OVERFLOW;
                        n_state = S_DONE;
                    end
                    n_off = neg_m[W_VAL-1:0];
                end else begin
                    if (r_m[W_VAL:W_VAL-1] != 2'b00) begin
                        n_st    = ST_OVERFLOW;
                        n_state = S_DONE;
                    end
                    n_off = r_m[W_VAL-1:0];
                end
            end
            S_SUM: begin
                n_state = S_DONE;
                if (sum_ovf) begin
                    n_st = ST_OVERFLOW;
                end else begin
                    case (r_op)
                        OP_FRAME: n_fo = sum;
                        OP_TIME:  n_to = sum;
                        default: begin
                            n_cur    = sum;
                            n_commit = 1'b1;
                        end
                    endcase
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_frame  = r_fo;
                    n_o_time   = r_to;
                    n_o_status = r_st;
                    n_state    = S_IDLE;
                    if (r_commit) begin
                        n_anchor_time = r_now;
                        case (r_op)
                            OP_PLAY: begin
                                n_anchor_frame = r_cur;
                                n_rate_num     = r_snum;
                                n_rate_den     = r_sden;
                                n_running      = 1'b1;
                            end
                            OP_PAUSE: begin
                                n_anchor_frame = r_cur;
                                n_running      = 1'b0;
                            end
                            default: begin
                                n_anchor_frame = r_frame;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and clock state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_o_valid      <= 1'b0;
            r_commit       <= 1'b0;
            r_anchor_frame <= '0;
            r_anchor_time  <= '0;
            r_rate_num     <= W_SNUM'(1);
            r_rate_den     <= W_SDEN'(1);
            r_running      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_o_valid      <= n_o_valid;
            r_commit       <= n_commit;
            r_anchor_frame <= n_anchor_frame;
            r_anchor_time  <= n_anchor_time;
            r_rate_num     <= n_rate_num;
            r_rate_den     <= n_rate_den;
            r_running      <= n_running;
        end
    end

    // Frame rate registers, written through the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fps_num <= FPS_NUM_RESET;
            r_fps_den <= FPS_DEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FPS_NUM: r_fps_num <= i_cfg_data;
                CFG_FPS_DEN: r_fps_den <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Transaction capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_now   <= i_now_ns;
            r_frame <= i_frame_number;
            r_snum  <= i_speed_numerator;
            r_sden  <= i_speed_denominator;
        end
    end

    // Working and output data registers.
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_a        <= n_a;
        r_t        <= n_t;
        r_b        <= n_b;
        r_neg      <= n_neg;
        r_up       <= n_up;
        r_m        <= n_m;
        r_off      <= n_off;
        r_cur      <= n_cur;
        r_fo       <= n_fo;
        r_to       <= n_to;
        r_st       <= n_st;
        r_o_frame  <= n_o_frame;
        r_o_time   <= n_o_time;
        r_o_status <= n_o_status;
    end

    assign o_valid     = r_o_valid;
    assign o_frame_out = r_o_frame;
    assign o_time_out  = r_o_time;
    assign o_status    = r_o_status;

endmodule

/* tb/anchored_playback_frame_clock_core_test.sv */
// Self-checking testbench for anchored_playback_frame_clock_core: directed and random commands
// through valid/ready handshakes, checked against an in-bench model of the frame clock.
// Depends on apfc_pkg and the RTL of the block.
module anchored_playback_frame_clock_core_test
    import apfc_pkg::*;
;

    localparam logic [W_OP-1:0] OP_UNKNOWN_FIRST = OP_TIME + 3'd1;
    localparam logic [W_OP-1:0] OP_UNKNOWN_LAST  = '1;
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [W_SNUM-1:0] S17_MAX = 17'sh0FFFF;
    localparam logic signed [W_SNUM-1:0] S17_MIN = 17'sh10000;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 66;

    // One command transaction as driven on the input channel.
    typedef struct {
        logic [W_OP-1:0]          op;
        longint                   now;
        longint                   frame;
        logic signed [W_SNUM-1:0] snum;
        logic [W_SDEN-1:0]        sden;
    } clock_cmd_t;

    // One answer as expected on the output channel.
    typedef struct {
        longint          frame_out;
        longint          time_out;
        logic [W_ST-1:0] status;
    } clock_answer_t;

    // Frame clock model and the queue of answers it has promised.
    class frame_clock_scoreboard;
        logic [W_FPS-1:0]         fps_num;
        logic [W_FPS-1:0]         fps_den;
        longint                   anchor_frame;
        longint                   anchor_time;
        logic signed [W_SNUM-1:0] rate_num;
        logic [W_SDEN-1:0]        rate_den;
        bit                       running;
        clock_answer_t            pending_answers[$];
        int                       mismatches;
        int                       answers_seen;
        int                       op_count[8];
        int                       status_seen[4];

        function new();
            fps_num      = FPS_NUM_RESET;
            fps_den      = FPS_DEN_RESET;
            anchor_frame = 0;
            anchor_time  = 0;
            rate_num     = 1;
            rate_den     = 1;
            running      = 1'b0;
        endfunction

        function void write_register(input logic [W_CIDX-1:0] idx, input logic [W_FPS-1:0] data);
            if (idx == CFG_FPS_NUM) begin
                fps_num = data;
            end else if (idx == CFG_FPS_DEN) begin
                fps_den = data;
            end
        endfunction

        // Signed add or subtract that reports whether the result fits in 64 bits.
        function bit sum_fits(input longint a, input longint b, input bit subtract,
                              output longint r);
            logic [64:0] w;
            w = subtract ? {a[63], a} - {b[63], b} : {a[63], a} + {b[63], b};
            r = longint'(w[63:0]);
            return w[64] == w[63];
        endfunction

        // x * m1*m2*m3 / (d1*d2*d3) with the sign of x and the rate, rounded per step.
        function bit scale(input longint x, input bit rate_neg,
                           input logic [63:0] m1, m2, m3, d1, d2, d3,
                           input bit ceil_mode, output longint res);
            logic [191:0] v;
            logic [191:0] rest;
            logic [63:0]  mag;
            logic [63:0]  divs[3];
            bit           neg;
            bit           up;
            mag = x < 0 ? 64'(-x) : 64'(x);
            neg = (x < 0) != rate_neg;
            up = ceil_mode ? !neg : neg;
            v = 192'(mag) * 192'(m1) * 192'(m2) * 192'(m3);
            divs[0] = d1;
            divs[1] = d2;
            divs[2] = d3;
            foreach (divs[k]) begin
                rest = v % 192'(divs[k]);
                v = v / 192'(divs[k]);
                if (up && rest != 0) begin
                    v = v + 192'd1;
                end
            end
            if (v[191:64] != 0) begin
                return 1'b0;
            end
            if (neg) begin
                if (v[63:0] > 64'h8000_0000_0000_0000) begin
                    return 1'b0;
                end
                res = -longint'(v[63:0]);
            end else begin
                if (v[63]) begin
                    return 1'b0;
                end
                res = longint'(v[63:0]);
            end
            return 1'b1;
        endfunction

        function logic [63:0] rate_size();
            logic [W_SNUM-1:0] m;
            m = rate_num[W_SNUM-1] ? -rate_num : rate_num;
            return 64'(m);
        endfunction

        function bit mapping_broken();
            return fps_num == 0 || fps_den == 0 || rate_num == 0 || rate_den == 0;
        endfunction

        // Frame on screen at a given time.
        function logic [W_ST-1:0] frame_showing(input longint now, output longint out);
            longint elapsed;
            longint off;
            out = 0;
            if (!running) begin
                out = anchor_frame;
                return ST_OK;
            end
            if (mapping_broken()) begin
                return ST_ZERO_RATE;
            end
            if (!sum_fits(now, anchor_time, 1'b1, elapsed)) begin
                return ST_OVERFLOW;
            end
            if (!scale(elapsed, rate_num < 0, 64'(fps_num), rate_size(), 64'd1,
                       64'(NS_PER_SEC), 64'(fps_den), 64'(rate_den), 1'b0, off)) begin
                return ST_OVERFLOW;
            end
            if (!sum_fits(anchor_frame, off, 1'b0, out)) begin
                return ST_OVERFLOW;
            end
            return ST_OK;
        endfunction

        // First nanosecond at which a frame shows.
        function logic [W_ST-1:0] due_time(input longint frame, output longint out);
            longint delta;
            longint el;
            out = 0;
            if (!running) begin
                if (frame == anchor_frame) begin
                    out = anchor_time;
                    return ST_OK;
                end
                return ST_PAUSED;
            end
            if (mapping_broken()) begin
                return ST_ZERO_RATE;
            end
            if (!sum_fits(frame, anchor_frame, 1'b1, delta)) begin
                return ST_OVERFLOW;
            end
            if (!scale(delta, rate_num < 0, 64'(NS_PER_SEC), 64'(fps_den), 64'(rate_den),
                       64'(fps_num), rate_size(), 64'd1, rate_num > 0, el)) begin
                return ST_OVERFLOW;
            end
            if (!sum_fits(anchor_time, el, 1'b0, out)) begin
                return ST_OVERFLOW;
            end
            return ST_OK;
        endfunction

        // An accepted command moves the clock state and promises one answer.
        function void note_command(input clock_cmd_t c);
            clock_answer_t a;
            longint        cur;
            a.frame_out = 0;
            a.time_out  = 0;
            a.status    = ST_OK;
            cur = 0;
            op_count[c.op]++;
            case (c.op)
                OP_PLAY: begin
                    if (c.snum == 0 || c.sden == 0) begin
                        a.status = ST_ZERO_RATE;
                    end else begin
                        if (running) begin
                            a.status = frame_showing(c.now, cur);
                        end
                        if (a.status == ST_OK) begin
                            if (running) begin
                                anchor_frame = cur;
                            end
                            anchor_time = c.now;
                            rate_num    = c.snum;
                            rate_den    = c.sden;
                            running     = 1'b1;
                        end
                    end
                end
                OP_PAUSE: begin
                    if (running) begin
                        a.status = frame_showing(c.now, cur);
                        if (a.status == ST_OK) begin
                            anchor_frame = cur;
                            anchor_time  = c.now;
                            running      = 1'b0;
                        end
                    end
                end
                OP_SEEK: begin
                    anchor_frame = c.frame;
                    anchor_time  = c.now;
                end
                OP_FRAME: begin
                    a.status = frame_showing(c.now, cur);
                    if (a.status == ST_OK) begin
                        a.frame_out = cur;
                    end
                end
                OP_TIME: begin
                    a.status = due_time(c.frame, cur);
                    if (a.status == ST_OK) begin
                        a.time_out = cur;
                    end
                end
                default: begin
                end
            endcase
            pending_answers.push_back(a);
        endfunction

        // Compare a result transaction with the oldest promised answer.
        function void check_answer(input logic [W_VAL-1:0] fo, input logic [W_VAL-1:0] to,
                                   input logic [W_ST-1:0] st);
            clock_answer_t want;
            answers_seen++;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result with nothing outstanding: frame %0d time %0d status %0d",
                             $signed(fo), $signed(to), st);
                end
                return;
            end
            want = pending_answers.pop_front();
            status_seen[want.status]++;
            if (fo !== want.frame_out || to !== want.time_out || st !== want.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch on result %0d: expected frame %0d time %0d status %0d",
                             answers_seen, want.frame_out, want.time_out, want.status);
                    $display("                       got      frame %0d time %0d status %0d",
                             $signed(fo), $signed(to), st);
                end
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [W_CIDX-1:0]        i_cfg_idx;
    logic [W_FPS-1:0]         i_cfg_data;
    logic                     i_valid;
    logic                     o_ready;
    logic [W_OP-1:0]          i_operation;
    logic signed [W_VAL-1:0]  i_now_ns;
    logic signed [W_VAL-1:0]  i_frame_number;
    logic signed [W_SNUM-1:0] i_speed_numerator;
    logic [W_SDEN-1:0]        i_speed_denominator;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [W_VAL-1:0]  o_frame_out;
    logic signed [W_VAL-1:0]  o_time_out;
    logic [W_ST-1:0]          o_status;

    frame_clock_scoreboard board;
    bit                    calm;
    longint                wall_ns;
    int                    rate_settings;

    anchored_playback_frame_clock_core u_dut (.*);

    // Clock with a period of two time units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle cycles before a transaction; none during calm stretches.
    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic longint extreme64();
        case ($urandom_range(0, 3))
            0: return S64_MIN;
            1: return S64_MAX;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic clock_cmd_t compose(input logic [W_OP-1:0] op, input longint now,
                                           input longint frame,
                                           input logic signed [W_SNUM-1:0] snum,
                                           input logic [W_SDEN-1:0] sden);
        clock_cmd_t c;
        c.op    = op;
        c.now   = now;
        c.frame = frame;
        c.snum  = snum;
        c.sden  = sden;
        return c;
    endfunction

    // Random command: mostly plausible times and frames around the anchor, some noise.
    function automatic clock_cmd_t random_command();
        clock_cmd_t c;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            c.op = OP_PLAY;
        end else if (pick < 24) begin
            c.op = OP_PAUSE;
        end else if (pick < 33) begin
            c.op = OP_SEEK;
        end else if (pick < 63) begin
            c.op = OP_FRAME;
        end else if (pick < 95) begin
            c.op = OP_TIME;
        end else begin
            c.op = W_OP'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
        end
        wall_ns += longint'($urandom_range(0, 40_000_000));
        case ($urandom_range(0, 11))
            0: c.now = {$urandom, $urandom};
            1: c.now = extreme64();
            2: c.now = board.anchor_time;
            3: c.now = board.anchor_time - longint'($urandom_range(0, 2_000_000_000));
            default: c.now = wall_ns + longint'($urandom_range(0, 2_000_000)) - 1_000_000;
        endcase
        case ($urandom_range(0, 11))
            0: c.frame = {$urandom, $urandom};
            1: c.frame = extreme64();
            2, 3: c.frame = board.anchor_frame;
            default: c.frame = board.anchor_frame + longint'($urandom_range(0, 200_000)) - 100_000;
        endcase
        case ($urandom_range(0, 9))
            0: c.snum = W_SNUM'($urandom);
            1: c.snum = 0;
            2: c.snum = $urandom_range(0, 1) ? S17_MIN : S17_MAX;
            default: begin
                c.snum = W_SNUM'($urandom_range(1, 8));
                if ($urandom_range(0, 2) == 0) begin
                    c.snum = -c.snum;
                end
            end
        endcase
        case ($urandom_range(0, 9))
            0: c.sden = W_SDEN'($urandom);
            1: c.sden = 0;
            2: c.sden = '1;
            default: c.sden = W_SDEN'($urandom_range(1, 4));
        endcase
        return c;
    endfunction

    // Drive one command transaction and wait until the block takes it.
    task automatic send_command(input clock_cmd_t c);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_operation         <= c.op;
        i_now_ns            <= c.now;
        i_frame_number      <= c.frame;
        i_speed_numerator   <= c.snum;
        i_speed_denominator <= c.sden;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        board.note_command(c);
    endtask

    // Stop sending and wait until every promised answer has been taken.
    task automatic wait_for_answers();
        i_valid <= 1'b0;
        while (board.pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // Write both frame rate registers, optionally followed by writes to the unused indexes.
    task automatic set_frame_rate(input logic [W_FPS-1:0] num, input logic [W_FPS-1:0] den,
                                  input bit stray);
        logic [W_CIDX-1:0] spare;
        logic [W_FPS-1:0]  junk;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FPS_NUM;
        i_cfg_data <= num;
        @(posedge i_clk);
        board.write_register(CFG_FPS_NUM, num);
        i_cfg_idx  <= CFG_FPS_DEN;
        i_cfg_data <= den;
        @(posedge i_clk);
        board.write_register(CFG_FPS_DEN, den);
        if (stray) begin
            spare = CFG_FPS_DEN + 1'b1;
            repeat (2) begin
                junk = W_FPS'($urandom);
                i_cfg_idx  <= spare;
                i_cfg_data <= junk;
                @(posedge i_clk);
                board.write_register(spare, junk);
                spare = spare + 1'b1;
            end
        end
        i_cfg_we <= 1'b0;
        rate_settings++;
    endtask

    // Result side: random stalls, then take and check one result transaction.
    task automatic receive_answers();
        int stall;
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            board.check_answer(o_frame_out, o_time_out, o_status);
        end
    endtask

    // Directed commands under the reset frame rate: paused cases, rejected rates,
    // forward and reverse play, rounding of due times and overflow on every path.
    task automatic run_directed();
        send_command(compose(OP_FRAME, 12345, 0, 1, 1));
        send_command(compose(OP_TIME, 0, 0, 1, 1));
        send_command(compose(OP_TIME, 0, 5, 1, 1));
        send_command(compose(OP_PAUSE, 777, 0, 1, 1));
        send_command(compose(OP_PLAY, 1000, 0, 0, 1));
        send_command(compose(OP_PLAY, 1000, 0, 1, 0));
        send_command(compose(OP_UNKNOWN_LAST, S64_MAX, S64_MIN, S17_MIN, '1));
        send_command(compose(OP_SEEK, 1000, 100, 1, 1));
        send_command(compose(OP_PLAY, 1000, 0, 1, 1));
        send_command(compose(OP_FRAME, 1000 + 64'sd1_000_000_000, 0, 1, 1));
        send_command(compose(OP_TIME, 0, 131, 1, 1));
        send_command(compose(OP_FRAME, S64_MIN, 0, 1, 1));
        send_command(compose(OP_TIME, 0, S64_MAX, 1, 1));
        send_command(compose(OP_PLAY, 2000, 0, S17_MIN, 1));
        send_command(compose(OP_FRAME, 3000, 0, 1, 1));
        send_command(compose(OP_TIME, 0, board.anchor_frame - 1, 1, 1));
        send_command(compose(OP_TIME, 0, S64_MIN, 1, 1));
        send_command(compose(OP_PLAY, 5000, 0, S17_MAX, '1));
        send_command(compose(OP_FRAME, S64_MAX, 0, 1, 1));
        send_command(compose(OP_PAUSE, 10000, 0, 1, 1));
        send_command(compose(OP_TIME, 0, board.anchor_frame, 1, 1));
        send_command(compose(OP_SEEK, S64_MAX, S64_MIN, 1, 1));
        send_command(compose(OP_PLAY, S64_MIN, 0, 1, '1));
        send_command(compose(OP_FRAME, S64_MAX, 0, 1, 1));
        send_command(compose(OP_UNKNOWN_FIRST, 0, 0, 0, 0));
    endtask

    // Main sequence: reset, directed part, then random phases over several frame rates.
    initial begin
        int               phase;
        logic [W_FPS-1:0] num;
        logic [W_FPS-1:0] den;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_FPS_NUM;
        i_cfg_data          = '0;
        i_valid             = 1'b0;
        i_operation         = OP_PLAY;
        i_now_ns            = '0;
        i_frame_number      = '0;
        i_speed_numerator   = '0;
        i_speed_denominator = '0;
        i_ready             = 1'b0;
        calm                = 1'b0;
        wall_ns             = 64'sd1_000_000_000_000;
        rate_settings       = 1;
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            receive_answers();
        join_none

        run_directed();

        for (phase = 0; phase < PHASES; phase++) begin
            wait_for_answers();
            case (phase)
                0: begin num = 24000; den = 1001; end
                1: begin num = '1; den = 1; end
                2: begin num = 1; den = '1; end
                3: begin num = '1; den = '1; end
                4: begin num = 0; den = 1; end
                5: begin num = 25; den = 0; end
                6: begin
                    num = W_FPS'($urandom_range(1, 1048575));
                    den = W_FPS'($urandom_range(1, 1048575));
                end
                7: begin num = 1; den = 1; end
                default: begin num = W_FPS'($urandom); den = W_FPS'($urandom); end
            endcase
            set_frame_rate(num, den, phase == 0);
            calm = (phase % 3) == 2;
            send_command(compose(OP_SEEK, wall_ns, longint'($urandom_range(0, 1000)), 1, 1));
            repeat (ITEMS_PER_PHASE) send_command(random_command());
        end

        // Drain, then leave room for any stray result to show up.
        wait_for_answers();
        repeat (160) @(posedge i_clk);
        $display("Covered %0d commands over %0d frame rate settings: %0d play, %0d pause,",
                 board.answers_seen, rate_settings, board.op_count[OP_PLAY],
                 board.op_count[OP_PAUSE]);
        $display("  %0d seek, %0d frame, %0d due time; status ok/zero/ovf/paused %0d/%0d/%0d/%0d.",
                 board.op_count[OP_SEEK], board.op_count[OP_FRAME], board.op_count[OP_TIME],
                 board.status_seen[ST_OK], board.status_seen[ST_ZERO_RATE],
                 board.status_seen[ST_OVERFLOW], board.status_seen[ST_PAUSED]);
        if (board.mismatches == 0 && board.pending_answers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
